// ===== design/acdsu_pkg.sv =====
// shared types, constants and aes byte functions for the cbc stream decryptor
// no dependencies; imported by every design module
package acdsu_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_KEY_A    = 3'd0;
    localparam logic [2:0] REG_KEY_B    = 3'd1;
    localparam logic [2:0] REG_KEY_C    = 3'd2;
    localparam logic [2:0] REG_KEY_D    = 3'd3;
    localparam logic [2:0] REG_KEY_MODE = 3'd4;

    // key size codes
    localparam logic [1:0] MODE_128 = 2'd0;
    localparam logic [1:0] MODE_192 = 2'd1;

    // queue depths
    localparam int IQ_DEPTH = 2;
    localparam int OQ_DEPTH = 4;

    // block handed from front to back
    typedef struct packed {
        logic [127:0] cipher;
        logic [127:0] chain;
        logic         fin;
    } t_blk;

    // one result
    typedef struct packed {
        logic [127:0] plain;
        logic [4:0]   nvalid;
        logic         eos;
    } t_res;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // multiply by x in gf(2^8)
    function automatic logic [7:0] f_xt(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // sbox on each byte of a key word
    function automatic logic [31:0] f_sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // inverse shift rows and inverse sbox; byte 0 sits in the top bits
    function automatic logic [127:0] f_isub(input logic [127:0] s);
        logic [127:0] t;
        int src;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = 4 * ((c + 4 - r) & 3) + r;
                t[127 - 8 * (4 * c + r) -: 8] = INV_SBOX[s[127 - 8 * src -: 8]];
            end
        end
        return t;
    endfunction

    // inverse mix columns
    function automatic logic [127:0] f_imix(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m9 [4];
        logic [7:0] m11 [4];
        logic [7:0] m13 [4];
        logic [7:0] m14 [4];
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                a[k]   = s[127 - 8 * (4 * c + k) -: 8];
                x2[k]  = f_xt(a[k]);
                x4[k]  = f_xt(x2[k]);
                x8[k]  = f_xt(x4[k]);
                m9[k]  = x8[k] ^ a[k];
                m11[k] = x8[k] ^ x2[k] ^ a[k];
                m13[k] = x8[k] ^ x4[k] ^ a[k];
                m14[k] = x8[k] ^ x4[k] ^ x2[k];
            end
            t[127 - 8 * (4 * c) -: 8]     = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
            t[127 - 8 * (4 * c + 1) -: 8] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
            t[127 - 8 * (4 * c + 2) -: 8] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
            t[127 - 8 * (4 * c + 3) -: 8] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
        end
        return t;
    endfunction

endpackage

// ===== design/acdsu_keyexp.sv =====
// key registers and sequential key schedule, one word per cycle
// depends on acdsu_pkg
module acdsu_keyexp import acdsu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [2:0]        i_cfg_index,
    input  logic [63:0]       i_cfg_data,
    output logic              o_ready,
    output logic [1:0]        o_mode,
    output logic [59:0][31:0] o_rk
);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [63:0]       r_key [4];
    logic [1:0]        r_mode;
    logic [1:0]        r_st;
    logic [59:0][31:0] r_rk;
    logic [31:0]       r_win [8];
    logic [5:0]        r_idx;
    logic [2:0]        r_m;
    logic [7:0]        r_rcon;

    logic [3:0]  w_nk;
    logic [31:0] w_kw [8];
    logic [31:0] w_load [8];
    logic [31:0] w_far;
    logic [31:0] w_prev;
    logic [31:0] w_t;
    logic [31:0] w_new;

    // key length in words
    always_comb begin
        unique case (r_mode)
            MODE_128: w_nk = 4'd4;
            MODE_192: w_nk = 4'd6;
            default:  w_nk = 4'd8;
        endcase
    end

    // raw key words and the initial window (newest word first)
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_kw[i] = (i % 2 == 1) ? r_key[i / 2][31:0] : r_key[i / 2][63:32];
        end
        for (int j = 0; j < 8; j++) begin
            unique case (r_mode)
                MODE_128: w_load[j] = w_kw[3'(3 - j)];
                MODE_192: w_load[j] = w_kw[3'(5 - j)];
                default:  w_load[j] = w_kw[3'(7 - j)];
            endcase
        end
    end

    // next schedule word
    always_comb begin
        w_prev = r_win[0];
        unique case (r_mode)
            MODE_128: w_far = r_win[3];
            MODE_192: w_far = r_win[5];
            default:  w_far = r_win[7];
        endcase
        if (r_m == 3'd0) begin
            w_t = f_sub_word({w_prev[23:0], w_prev[31:24]}) ^ {r_rcon, 24'h0};
        end else if (w_nk == 4'd8 && r_m == 3'd4) begin
            w_t = f_sub_word(w_prev);
        end else begin
            w_t = w_prev;
        end
        w_new = w_far ^ w_t;
    end

    // register writes restart the schedule
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) r_key[i] <= '0;
            r_mode <= MODE_128;
            r_st   <= ST_LOAD;
        end else if (i_cfg_valid && i_cfg_index <= REG_KEY_MODE) begin
            unique case (i_cfg_index)
                REG_KEY_A: r_key[0] <= i_cfg_data;
                REG_KEY_B: r_key[1] <= i_cfg_data;
                REG_KEY_C: r_key[2] <= i_cfg_data;
                REG_KEY_D: r_key[3] <= i_cfg_data;
                default:   r_mode   <= i_cfg_data[1:0];
            endcase
            r_st <= ST_LOAD;
        end else begin
            unique case (r_st)
                ST_LOAD: begin
                    for (int j = 0; j < 8; j++) begin
                        r_win[j] <= w_load[j];
                        r_rk[j]  <= w_kw[j];
                    end
                    r_idx  <= {2'b00, w_nk};
                    r_m    <= 3'd0;
                    r_rcon <= 8'h01;
                    r_st   <= ST_RUN;
                end
                ST_RUN: begin
                    r_rk[r_idx] <= w_new;
                    r_win[0]    <= w_new;
                    for (int j = 1; j < 8; j++) r_win[j] <= r_win[j - 1];
                    r_m <= ({1'b0, r_m} == w_nk - 4'd1) ? 3'd0 : r_m + 3'd1;
                    if (r_m == 3'd0) r_rcon <= f_xt(r_rcon);
                    if (r_idx == 6'd59) r_st <= ST_DONE;
                    r_idx <= r_idx + 6'd1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_ready = (r_st == ST_DONE);
    assign o_mode  = r_mode;
    assign o_rk    = r_rk;

endmodule

// ===== design/acdsu_front.sv =====
// front part: takes blocks, tracks iv and end of stream, queues work for the back
// depends on acdsu_pkg
module acdsu_front import acdsu_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_key_ready,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [127:0] i_cipher,
    input  logic         i_fin,
    output logic         o_valid,
    input  logic         i_ready,
    output t_blk         o_blk
);

    t_blk         r_q [IQ_DEPTH];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         r_iv_seen;
    logic         r_done;
    logic [127:0] r_chain;

    logic w_acc;
    logic w_push;
    logic w_pop;

    assign o_ready = i_key_ready && (r_cnt < 2'(IQ_DEPTH));
    assign w_acc   = i_valid && o_ready;
    assign w_push  = w_acc && !r_done && r_iv_seen;
    assign o_valid = (r_cnt != 2'd0);
    assign o_blk   = r_q[r_rp];
    assign w_pop   = o_valid && i_ready;

    // stream tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv_seen <= 1'b0;
            r_done    <= 1'b0;
        end else if (w_acc && !r_done) begin
            r_iv_seen <= 1'b1;
            r_done    <= i_fin;
        end
    end

    // chain value is the previous ciphertext or the iv
    always_ff @(posedge i_clk) begin
        if (w_acc && !r_done) r_chain <= i_cipher;
    end

    // work queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= '{cipher: i_cipher, chain: r_chain, fin: i_fin};
                r_wp      <= ~r_wp;
            end
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

// ===== design/acdsu_back.sv =====
// back part: pipelined inverse rounds, cbc xor, hold-back and unpadding, result queue
// depends on acdsu_pkg
module acdsu_back import acdsu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_mode,
    input  logic [59:0][31:0] i_rk,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_blk              i_blk,
    output logic              o_valid,
    input  logic              i_ready,
    output t_res              o_res
);

    // stage 14 holds the state after the first key add, stage 0 the plaintext
    logic [127:0] r_st  [15];
    logic [127:0] r_ch  [15];
    logic         r_fin [15];
    logic [14:0]  r_vld;

    logic [127:0] r_held;
    logic         r_held_vld;

    t_res         r_oq [OQ_DEPTH];
    logic [1:0]   r_owp;
    logic [1:0]   r_orp;
    logic [2:0]   r_ocnt;

    logic         w_en;
    logic [3:0]   w_nr;
    logic [127:0] w_rk_last;
    logic [127:0] w_nxt [14];
    logic [7:0]   w_last;
    logic [4:0]   w_nvalid;
    logic [127:0] w_masked;
    t_res         w_fin_res;
    t_res         w_held_res;
    t_res         w_e0;
    logic         w_take;
    logic [1:0]   w_push;
    logic         w_pop;

    // pipeline moves only while the result queue has room for two
    assign w_en    = (r_ocnt <= 3'(OQ_DEPTH - 2));
    assign o_ready = w_en;

    // round count and the key of the first add
    always_comb begin
        unique case (i_mode)
            MODE_128: begin
                w_nr      = 4'd10;
                w_rk_last = {i_rk[40], i_rk[41], i_rk[42], i_rk[43]};
            end
            MODE_192: begin
                w_nr      = 4'd12;
                w_rk_last = {i_rk[48], i_rk[49], i_rk[50], i_rk[51]};
            end
            default: begin
                w_nr      = 4'd14;
                w_rk_last = {i_rk[56], i_rk[57], i_rk[58], i_rk[59]};
            end
        endcase
    end

    // one inverse round per stage; rounds beyond the key's count pass through
    always_comb begin
        for (int r = 1; r < 14; r++) begin
            if (4'(r) < w_nr) begin
                w_nxt[r] = f_imix(f_isub(r_st[r + 1]) ^
                           {i_rk[4 * r], i_rk[4 * r + 1], i_rk[4 * r + 2], i_rk[4 * r + 3]});
            end else begin
                w_nxt[r] = r_st[r + 1];
            end
        end
        w_nxt[0] = f_isub(r_st[1]) ^ {i_rk[0], i_rk[1], i_rk[2], i_rk[3]} ^ r_ch[1];
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {i_valid, r_vld[14:1]};
        end
    end

    // stage data
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_st[14]  <= i_blk.cipher ^ w_rk_last;
            r_ch[14]  <= i_blk.chain;
            r_fin[14] <= i_blk.fin;
            for (int r = 0; r < 14; r++) begin
                r_st[r]  <= w_nxt[r];
                r_ch[r]  <= r_ch[r + 1];
                r_fin[r] <= r_fin[r + 1];
            end
        end
    end

    // unpadding of the final block
    always_comb begin
        w_last   = r_st[0][7:0];
        w_nvalid = (w_last > 8'd16) ? 5'd0 : 5'd16 - w_last[4:0];
        for (int n = 0; n < 16; n++) begin
            w_masked[127 - 8 * n -: 8] = (5'(n) < w_nvalid) ? r_st[0][127 - 8 * n -: 8] : 8'h00;
        end
        w_fin_res  = '{plain: w_masked, nvalid: w_nvalid, eos: 1'b1};
        w_held_res = '{plain: r_held, nvalid: 5'd16, eos: 1'b0};
        w_e0       = r_held_vld ? w_held_res : w_fin_res;
        w_take     = w_en && r_vld[0];
        w_push     = w_take ? ({1'b0, r_held_vld} + {1'b0, r_fin[0]}) : 2'd0;
    end

    // hold back one full block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_vld <= 1'b0;
        end else if (w_take) begin
            r_held_vld <= !r_fin[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && !r_fin[0]) r_held <= r_st[0];
    end

    // result queue, up to two writes a cycle
    assign o_valid = (r_ocnt != 3'd0);
    assign o_res   = r_oq[r_orp];
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 2'd0;
            r_orp  <= 2'd0;
            r_ocnt <= 3'd0;
        end else begin
            if (w_push != 2'd0) r_oq[r_owp] <= w_e0;
            if (w_push == 2'd2) r_oq[r_owp + 2'd1] <= w_fin_res;
            r_owp  <= r_owp + w_push;
            if (w_pop) r_orp <= r_orp + 2'd1;
            r_ocnt <= r_ocnt + {1'b0, w_push} - {2'b00, w_pop};
        end
    end

`ifndef SYNTHESIS
    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= 3'(OQ_DEPTH))
        else $error("result queue overflow");

    a_fin_clears_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && r_fin[0]) |=> !r_held_vld)
        else $error("held block survives the final block");

    a_oq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push == 2'd0 && !w_pop) |=> $stable(r_ocnt))
        else $error("result count moved without a push or pop");

    a_two_needs_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push == 2'd2) |-> (r_held_vld && r_fin[0]))
        else $error("double push without a held block");
`endif

endmodule

// ===== design/aes_cbc_decrypt_stream_unpad.sv =====
// top level of the aes-cbc stream decryptor with pkcs7 unpadding
// depends on acdsu_pkg, acdsu_keyexp, acdsu_front, acdsu_back
//
// usage:
//   configuration channel (i_cfg_*): index 0..3 write the key words a..d, index 4 the
//   key size (0 = 128, 1 = 192, 2 or 3 = 256 bit); other indexes are ignored. each write
//   reruns the key schedule, one word per cycle; while it runs the input channel is not
//   ready. reset loads the all-zero 128 bit key the same way.
//   input channel (s_axis_*): one 16 byte block per transaction, tlast marks the last
//   block. the first block is the iv and gives no result; blocks after the last are
//   dropped until reset.
//   output channel (m_axis_*): full plaintext blocks, one held back, and the unpadded
//   final block with tlast high.
//   throughput is one block per cycle, from the fifteen-stage round pipeline, while the
//   key schedule is done and the result queue has room.
//   a stalled receiver fills a four-entry result queue and then stalls the pipeline and
//   the input channel; nothing is lost.
module aes_cbc_decrypt_stream_unpad import acdsu_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data,
    // input blocks
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // cipher_first_half, cipher_second_half
    input  logic         s_axis_tlast,   // final_block
    // results
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata,   // plain_first_half, plain_second_half, valid_bytes
    output logic         m_axis_tlast    // end_of_stream
);

    logic              w_key_ready;
    logic [1:0]        w_mode;
    logic [59:0][31:0] w_rk;
    logic              w_blk_valid;
    logic              w_blk_ready;
    t_blk              w_blk;
    t_res              w_res;

    assign o_cfg_ready = 1'b1;

    // key schedule
    acdsu_keyexp u_keyexp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_ready     (w_key_ready),
        .o_mode      (w_mode),
        .o_rk        (w_rk)
    );

    // input side
    acdsu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key_ready (w_key_ready),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_cipher    ({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
        .i_fin       (s_axis_tlast),
        .o_valid     (w_blk_valid),
        .i_ready     (w_blk_ready),
        .o_blk       (w_blk)
    );

    // decrypt and result side
    acdsu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (w_mode),
        .i_rk    (w_rk),
        .i_valid (w_blk_valid),
        .o_ready (w_blk_ready),
        .i_blk   (w_blk),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (w_res)
    );

    assign m_axis_tdata = {3'b000, w_res.nvalid, w_res.plain[63:0], w_res.plain[127:64]};
    assign m_axis_tlast = w_res.eos;

endmodule
